>>> sv/psd_pkg.sv
// Shared widths, region codes and pipeline stage types for point_segment_distance.
// No dependencies; every other file refers to this package by scoped names.
package psd_pkg;

  // Coordinates are signed fixed point. The fraction bits pass straight
  // through, so the datapath only depends on the coordinate width.
  localparam int unsigned COORD_WIDTH = 16;

  localparam int unsigned DIFF_W = COORD_WIDTH + 1;       // coordinate difference
  localparam int unsigned PROD_W = 2 * COORD_WIDTH + 2;   // signed product or sum of two
  localparam int unsigned SQ_W   = 2 * COORD_WIDTH + 1;   // squared length, quotient
  localparam int unsigned DIST_W = COORD_WIDTH + 1;       // distance
  localparam int unsigned NUM_W  = 2 * SQ_W;              // squared cross product
  localparam int unsigned LO_W   = (SQ_W + 1) / 2;        // low half of the cross product
  localparam int unsigned HI_W   = SQ_W - LO_W;           // high half of the cross product
  localparam int unsigned REM_W  = DIST_W + 2;            // square root remainder
  localparam int unsigned IN_W   = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((DIST_W + 2 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REG_INTERIOR = 2'd0,
    REG_END_B    = 2'd1,
    REG_END_A    = 2'd2,
    REG_DEGEN    = 2'd3
  } region_e;

  // One division cell's working set: partial remainder, the low numerator
  // bits that shift out as quotient bits shift in, and the divisor.
  typedef struct packed {
    region_e           region;
    logic [SQ_W-1:0]   rem;
    logic [SQ_W-1:0]   low;
    logic [SQ_W-1:0]   den;
  } div_stage_t;

  // One square root cell's working set.
  typedef struct packed {
    region_e             region;
    logic [REM_W-1:0]    rem;
    logic [DIST_W-1:0]   root;
    logic [2*DIST_W-1:0] x;
  } sqrt_stage_t;

endpackage

>>> sv/point_segment_distance.sv
// Top level of the point to segment distance pipeline.
// Depends on psd_pkg, psd_front, psd_div_cell and psd_sqrt_cell.
//
// Usage: each slave-side transaction carries a query point P and segment ends
// A and B as signed fixed-point coordinates. Each master-side transaction
// returns the floor of the distance from P to the segment, with the same
// fraction bits, and a region code: interior projection, nearest end B,
// nearest end A, or degenerate segment (A equal to B).
// The datapath is a five-stage arithmetic front end followed by a chain of
// division cells (one quotient bit each, 33 cells) that forms the squared
// perpendicular distance for the interior case and carries the squared end
// distance through unchanged otherwise, then a chain of square root cells
// (one root bit each, 17 cells). One transaction is accepted every cycle while
// the receiver keeps taking results.
// Every stage holds a valid bit and loads when it is empty or its contents
// move on, so when the receiver stalls, bubbles are squeezed out and input is
// still accepted until every stage is full. Results come out in input order.
// Reset empties all stages; there is nothing else to initialize.
module point_segment_distance (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0 up: point_x, point_y, end_a_x, end_a_y, end_b_x, end_b_y.
  input  logic [psd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0 up: distance, region, then zero fill.
  output logic [psd_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned CW    = psd_pkg::COORD_WIDTH;
  localparam int unsigned NDIV  = psd_pkg::SQ_W;
  localparam int unsigned NSQRT = psd_pkg::DIST_W;

  psd_pkg::div_stage_t  div_s [NDIV+1];
  logic [NDIV:0]        div_valid, div_ready;
  psd_pkg::sqrt_stage_t sqrt_s [NSQRT+1];
  logic [NSQRT:0]       sqrt_valid, sqrt_ready;

  psd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .px_i        (s_axis_tdata[CW-1:0]),
    .py_i        (s_axis_tdata[2*CW-1:CW]),
    .ax_i        (s_axis_tdata[3*CW-1:2*CW]),
    .ay_i        (s_axis_tdata[4*CW-1:3*CW]),
    .bx_i        (s_axis_tdata[5*CW-1:4*CW]),
    .by_i        (s_axis_tdata[6*CW-1:5*CW]),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_s[0])
  );

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    psd_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[i]),
      .in_ready_o  (div_ready[i]),
      .in_data_i   (div_s[i]),
      .out_valid_o (div_valid[i+1]),
      .out_ready_i (div_ready[i+1]),
      .out_data_o  (div_s[i+1])
    );
  end

  // The division chain ends in the squared distance; seed the root chain.
  always_comb begin
    sqrt_s[0].region = div_s[NDIV].region;
    sqrt_s[0].rem    = '0;
    sqrt_s[0].root   = '0;
    sqrt_s[0].x      = {{(2*psd_pkg::DIST_W-psd_pkg::SQ_W){1'b0}}, div_s[NDIV].low};
  end
  assign sqrt_valid[0]   = div_valid[NDIV];
  assign div_ready[NDIV] = sqrt_ready[0];

  for (genvar i = 0; i < NSQRT; i++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sqrt_valid[i]),
      .in_ready_o  (sqrt_ready[i]),
      .in_data_i   (sqrt_s[i]),
      .out_valid_o (sqrt_valid[i+1]),
      .out_ready_i (sqrt_ready[i+1]),
      .out_data_o  (sqrt_s[i+1])
    );
  end

  // The last root cell's register is the output register.
  assign sqrt_ready[NSQRT] = m_axis_tready;
  assign m_axis_tvalid     = sqrt_valid[NSQRT];
  assign m_axis_tdata      = psd_pkg::OUT_W'({sqrt_s[NSQRT].region, sqrt_s[NSQRT].root});

  // Input can only be refused when the whole pipe is backed up by the receiver.
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output is free");

  // An interior projection always has a nonzero divisor.
  a_interior_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[0] && div_s[0].region == psd_pkg::REG_INTERIOR) |-> (div_s[0].den != '0))
    else $error("interior case with a zero squared length");

  // End cases bypass the division cells with the remainder left at zero.
  a_bypass_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[NDIV] && div_s[NDIV].region != psd_pkg::REG_INTERIOR)
      |-> (div_s[NDIV].rem == '0))
    else $error("division cells altered a bypassed transaction");

endmodule

>>> sv/psd_front.sv
// Arithmetic front end: differences, products, case selection and the squared
// cross product, in five registered stages. Depends on psd_pkg.
module psd_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] px_i,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] py_i,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] ax_i,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] ay_i,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] bx_i,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] by_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output psd_pkg::div_stage_t                    out_data_o
);

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] valid_q;
  logic [NSTG:0]   rdy;

  // Stage 1: differences.
  logic signed [psd_pkg::DIFF_W-1:0] lx_q, ly_q, qx_q, qy_q, rx_q, ry_q;
  // Stage 2: products.
  logic signed [psd_pkg::PROD_W-1:0] lxlx_q, lyly_q, qxqx_q, qyqy_q, rxrx_q, ryry_q;
  logic signed [psd_pkg::PROD_W-1:0] lxqx_q, lyqy_q, lxqy_q, lyqx_q;
  // Stage 3: case selection.
  psd_pkg::region_e              region3_q, region3_d;
  logic [psd_pkg::SQ_W-1:0]      val3_q, val3_d, den3_q, cra3_q, cra3_d;
  logic signed [psd_pkg::PROD_W-1:0] nline, npoint, nra, dot, cr, crneg;
  // Stage 4: partial products of the cross product square.
  psd_pkg::region_e                  region4_q;
  logic [psd_pkg::SQ_W-1:0]          val4_q, den4_q;
  logic [2*psd_pkg::LO_W-1:0]        ll4_q;
  logic [psd_pkg::LO_W+psd_pkg::HI_W-1:0] hl4_q;
  logic [2*psd_pkg::HI_W-1:0]        hh4_q;
  logic [psd_pkg::LO_W-1:0]          cr_lo;
  logic [psd_pkg::HI_W-1:0]          cr_hi;
  // Stage 5: division cell seed.
  logic [psd_pkg::NUM_W-1:0]         num;
  psd_pkg::div_stage_t               data5_q, data5_d;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NSTG-1];
  assign out_data_o  = data5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_comb begin
    nline  = lxlx_q + lyly_q;
    npoint = qxqx_q + qyqy_q;
    nra    = rxrx_q + ryry_q;
    dot    = lxqx_q + lyqy_q;
    cr     = lxqy_q - lyqx_q;
    crneg  = -cr;
    cra3_d = cr[psd_pkg::PROD_W-1] ? crneg[psd_pkg::SQ_W-1:0] : cr[psd_pkg::SQ_W-1:0];
    if (nline == '0) begin
      region3_d = psd_pkg::REG_DEGEN;
      val3_d    = npoint[psd_pkg::SQ_W-1:0];
    end else if (dot <= 0) begin
      region3_d = psd_pkg::REG_END_B;
      val3_d    = npoint[psd_pkg::SQ_W-1:0];
    end else if (dot >= nline) begin
      region3_d = psd_pkg::REG_END_A;
      val3_d    = nra[psd_pkg::SQ_W-1:0];
    end else begin
      region3_d = psd_pkg::REG_INTERIOR;
      val3_d    = '0;
    end
  end

  assign cr_lo = cra3_q[psd_pkg::LO_W-1:0];
  assign cr_hi = cra3_q[psd_pkg::SQ_W-1:psd_pkg::LO_W];

  always_comb begin
    num = (psd_pkg::NUM_W'(hh4_q) << (2 * psd_pkg::LO_W))
        + (psd_pkg::NUM_W'(hl4_q) << (psd_pkg::LO_W + 1))
        + psd_pkg::NUM_W'(ll4_q);
    data5_d.region = region4_q;
    data5_d.den    = den4_q;
    if (region4_q == psd_pkg::REG_INTERIOR) begin
      data5_d.rem = num[psd_pkg::NUM_W-1:psd_pkg::SQ_W];
      data5_d.low = num[psd_pkg::SQ_W-1:0];
    end else begin
      data5_d.rem = '0;
      data5_d.low = val4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      lx_q <= ax_i - bx_i;
      ly_q <= ay_i - by_i;
      qx_q <= px_i - bx_i;
      qy_q <= py_i - by_i;
      rx_q <= px_i - ax_i;
      ry_q <= py_i - ay_i;
    end
    if (rdy[1] && valid_q[0]) begin
      lxlx_q <= lx_q * lx_q;
      lyly_q <= ly_q * ly_q;
      qxqx_q <= qx_q * qx_q;
      qyqy_q <= qy_q * qy_q;
      rxrx_q <= rx_q * rx_q;
      ryry_q <= ry_q * ry_q;
      lxqx_q <= lx_q * qx_q;
      lyqy_q <= ly_q * qy_q;
      lxqy_q <= lx_q * qy_q;
      lyqx_q <= ly_q * qx_q;
    end
    if (rdy[2] && valid_q[1]) begin
      region3_q <= region3_d;
      val3_q    <= val3_d;
      den3_q    <= nline[psd_pkg::SQ_W-1:0];
      cra3_q    <= cra3_d;
    end
    if (rdy[3] && valid_q[2]) begin
      region4_q <= region3_q;
      val4_q    <= val3_q;
      den4_q    <= den3_q;
      ll4_q     <= cr_lo * cr_lo;
      hl4_q     <= cr_hi * cr_lo;
      hh4_q     <= cr_hi * cr_hi;
    end
    if (rdy[4] && valid_q[3]) begin
      data5_q <= data5_d;
    end
  end

endmodule

>>> sv/psd_div_cell.sv
// One restoring division cell: one quotient bit per cell, bypassed for end cases.
// Depends on psd_pkg.
module psd_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psd_pkg::div_stage_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psd_pkg::div_stage_t out_data_o
);

  logic                valid_q;
  psd_pkg::div_stage_t data_q, data_d;
  logic [psd_pkg::SQ_W:0] trial, diff;
  logic                ge;

  always_comb begin
    data_d = in_data_i;
    trial  = {in_data_i.rem, in_data_i.low[psd_pkg::SQ_W-1]};
    diff   = trial - {1'b0, in_data_i.den};
    ge     = trial >= {1'b0, in_data_i.den};
    if (in_data_i.region == psd_pkg::REG_INTERIOR) begin
      data_d.rem = ge ? diff[psd_pkg::SQ_W-1:0] : trial[psd_pkg::SQ_W-1:0];
      data_d.low = {in_data_i.low[psd_pkg::SQ_W-2:0], ge};
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= data_d;
  end

endmodule

>>> sv/psd_sqrt_cell.sv
// One integer square root cell: settles one root bit from two radicand bits.
// Depends on psd_pkg.
module psd_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psd_pkg::sqrt_stage_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output psd_pkg::sqrt_stage_t out_data_o
);

  logic                 valid_q;
  psd_pkg::sqrt_stage_t data_q, data_d;
  logic [psd_pkg::REM_W-1:0] shifted, trial, diff;
  logic                 ge;

  always_comb begin
    data_d  = in_data_i;
    shifted = {in_data_i.rem[psd_pkg::REM_W-3:0],
               in_data_i.x[2*psd_pkg::DIST_W-1 -: 2]};
    trial   = {in_data_i.root, 2'b01};
    diff    = shifted - trial;
    ge      = shifted >= trial;
    data_d.rem  = ge ? diff : shifted;
    data_d.root = {in_data_i.root[psd_pkg::DIST_W-2:0], ge};
    data_d.x    = {in_data_i.x[2*psd_pkg::DIST_W-3:0], 2'b00};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= data_d;
  end

endmodule
